// ===== design/rsc_pkg.sv =====
// rsc_pkg: shared types, constants and character helpers for the radix string converter
// depends on: nothing
package rsc_pkg;

    localparam int ACC_W   = 32;
    localparam int CNT_W   = 4;
    localparam int BASE_W  = 5;
    localparam int DIGIT_W = 4;
    localparam int CHAR_W  = 8;

    localparam logic [CHAR_W-1:0] CHAR_UPPER_A  = 8'd65;
    localparam logic [CHAR_W-1:0] CHAR_ZERO     = 8'd48;
    localparam logic [CHAR_W-1:0] CHAR_SPACE    = 8'd32;
    localparam logic [CHAR_W-1:0] CHAR_E        = 8'd69;
    localparam logic [CHAR_W-1:0] CHAR_R        = 8'd82;
    localparam logic [CHAR_W-1:0] CHAR_O        = 8'd79;
    localparam logic [CHAR_W-1:0] ALPHA_OFFSET  = 8'd55;
    localparam logic [BASE_W-1:0] BASE_MIN      = 5'd2;
    localparam logic [BASE_W-1:0] BASE_MAX      = 5'd16;

    typedef struct packed {
        logic [CHAR_W-1:0] digit_char;
        logic [BASE_W-1:0] from_base;
        logic [BASE_W-1:0] to_base;
        logic              last_digit;
    } in_beat_t;

    typedef struct packed {
        logic [CHAR_W-1:0] out_char;
        logic              last_char;
    } out_beat_t;

    typedef enum logic [1:0] {
        FMT_DIGITS,
        FMT_ZERO,
        FMT_ERROR
    } fmt_mode_t;

    typedef struct packed {
        fmt_mode_t        mode;
        logic [CNT_W-1:0] count;
        logic [CNT_W-1:0] tail;
    } fmt_ctl_t;

    typedef struct packed {
        logic               en;
        logic [CNT_W-1:0]   idx;
        logic [DIGIT_W-1:0] digit;
    } store_wr_t;

    function automatic logic [CHAR_W-1:0] digit_value(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] v;
        if (c >= CHAR_UPPER_A)
            v = c - ALPHA_OFFSET;
        else
            v = c - CHAR_ZERO;
        return v;
    endfunction

    function automatic logic [CHAR_W-1:0] digit_ascii(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d > 4'd9)
            c = CHAR_W'(d) + ALPHA_OFFSET;
        else
            c = CHAR_W'(d) + CHAR_ZERO;
        return c;
    endfunction

    // letters of the error word counted from the right edge of the field
    function automatic logic [CHAR_W-1:0] error_char(input logic [CNT_W-1:0] tail);
        logic [CHAR_W-1:0] c;
        case (tail)
            4'd0:    c = CHAR_R;
            4'd1:    c = CHAR_O;
            4'd2:    c = CHAR_R;
            4'd3:    c = CHAR_R;
            4'd4:    c = CHAR_E;
            default: c = CHAR_SPACE;
        endcase
        return c;
    endfunction

endpackage

// ===== design/rsc_divider.sv =====
// rsc_divider: shared restoring divider, one quotient bit per cycle
// depends on: rsc_pkg
module rsc_divider
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [rsc_pkg::ACC_W-1:0]    dividend,
    input  logic [rsc_pkg::BASE_W-1:0]   divisor,
    output logic                         done,
    output logic [rsc_pkg::ACC_W-1:0]    quotient,
    output logic [rsc_pkg::BASE_W-1:0]   remainder
);

    localparam int STEP_W = $clog2(rsc_pkg::ACC_W);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(rsc_pkg::ACC_W - 1);

    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    logic [STEP_W-1:0]            step_reg, step_next;
    logic [rsc_pkg::ACC_W-1:0]    quot_reg, quot_next;
    logic [rsc_pkg::BASE_W-1:0]   rem_reg, rem_next;
    logic [rsc_pkg::BASE_W:0]     trial;
    logic                         fits;

    always_comb
    begin
        trial     = {rem_reg, quot_reg[rsc_pkg::ACC_W-1]};
        fits      = trial >= {1'b0, divisor};
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            quot_next = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            quot_next = {quot_reg[rsc_pkg::ACC_W-2:0], fits};
            if (fits)
                rem_next = rsc_pkg::BASE_W'(trial - {1'b0, divisor});
            else
                rem_next = trial[rsc_pkg::BASE_W-1:0];
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
    end

    assign done      = done_reg;
    assign quotient  = quot_reg;
    assign remainder = rem_reg;

endmodule

// ===== design/rsc_field_fmt.sv =====
// rsc_field_fmt: output digit store and right-justified field character selection
// depends on: rsc_pkg
module rsc_field_fmt #(
    parameter int FIELD_WIDTH = 7
)
(
    input  logic                          clk,
    input  rsc_pkg::store_wr_t            wr,
    input  logic [rsc_pkg::CNT_W-1:0]     rd_idx,
    input  rsc_pkg::fmt_ctl_t             ctl,
    output logic [rsc_pkg::CHAR_W-1:0]    field_char
);

    localparam int IDX_W = (FIELD_WIDTH > 1) ? $clog2(FIELD_WIDTH) : 1;

    logic [rsc_pkg::DIGIT_W-1:0] store_mem [FIELD_WIDTH];
    logic [rsc_pkg::DIGIT_W-1:0] rd_digit_reg;

    // read address is the next tail so the digit lines up with ctl.tail
    always_ff @(posedge clk)
    begin
        if (wr.en)
            store_mem[wr.idx[IDX_W-1:0]] <= wr.digit;
        rd_digit_reg <= store_mem[rd_idx[IDX_W-1:0]];
    end

    always_comb
    begin
        case (ctl.mode)
            rsc_pkg::FMT_ERROR:
                field_char = rsc_pkg::error_char(ctl.tail);
            rsc_pkg::FMT_ZERO:
                field_char = (ctl.tail == '0) ? rsc_pkg::CHAR_ZERO : rsc_pkg::CHAR_SPACE;
            rsc_pkg::FMT_DIGITS:
                field_char = (ctl.tail < ctl.count) ? rsc_pkg::digit_ascii(rd_digit_reg)
                                                    : rsc_pkg::CHAR_SPACE;
            default:
                field_char = rsc_pkg::CHAR_SPACE;
        endcase
    end

endmodule

// ===== design/radix_string_converter_core.sv =====
// radix_string_converter_core: digit string accumulator and radix converter, top level
// depends on: rsc_pkg, rsc_divider, rsc_field_fmt
//
//   channel | direction | payload            | handshake
//   in      | into core | rsc_pkg::in_beat_t  | in_valid / in_ready
//   out     | from core | rsc_pkg::out_beat_t | out_valid / out_ready
//
// a character that is not last costs one multiply-accumulate at accept
// a last character is converted by the shared bit-serial divider, one division per
// target digit with a check of the value before each, then FIELD_WIDTH beats go
// out at one per cycle while out_ready stays high
// reset clears accumulator, overflow flag, digit count and handshake state
// in_ready is low from a last character until its final beat is loaded
module radix_string_converter_core #(
    parameter int FIELD_WIDTH = 7
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  rsc_pkg::in_beat_t   in_beat,
    output logic                out_valid,
    input  logic                out_ready,
    output rsc_pkg::out_beat_t  out_beat
);

    localparam logic [rsc_pkg::CNT_W-1:0] FW_CNT   = rsc_pkg::CNT_W'(FIELD_WIDTH);
    localparam logic [rsc_pkg::CNT_W-1:0] TAIL_TOP = rsc_pkg::CNT_W'(FIELD_WIDTH - 1);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_CHECK = 4'b0010,
        ST_DIV   = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

    state_t                         state_reg, state_next;
    logic [rsc_pkg::ACC_W-1:0]      acc_reg, acc_next;
    logic                           ovf_reg, ovf_next;
    logic                           err_reg, err_next;
    logic [rsc_pkg::ACC_W-1:0]      value_reg, value_next;
    logic [rsc_pkg::BASE_W-1:0]     to_base_reg, to_base_next;
    logic [rsc_pkg::CNT_W-1:0]      count_reg, count_next;
    logic [rsc_pkg::CNT_W-1:0]      tail_reg, tail_next;
    rsc_pkg::fmt_mode_t             mode_reg, mode_next;
    logic                           out_valid_reg, out_valid_next;
    rsc_pkg::out_beat_t             out_beat_reg, out_beat_next;

    logic                           in_fire;
    logic                           emit_load;
    logic [rsc_pkg::ACC_W+4:0]      mac_prod;
    logic [rsc_pkg::ACC_W+5:0]      mac_sum;
    logic                           mac_ovf;
    logic                           base_bad;
    logic                           div_start;
    logic                           div_done;
    logic [rsc_pkg::ACC_W-1:0]      div_quot;
    logic [rsc_pkg::BASE_W-1:0]     div_rem;
    rsc_pkg::store_wr_t             store_wr;
    rsc_pkg::fmt_ctl_t              fmt_ctl;
    logic [rsc_pkg::CHAR_W-1:0]     field_char;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign emit_load = (state_reg == ST_EMIT) && (!out_valid_reg || out_ready);

    assign mac_prod = (rsc_pkg::ACC_W+5)'(acc_reg) * (rsc_pkg::ACC_W+5)'(in_beat.from_base);
    assign mac_sum  = (rsc_pkg::ACC_W+6)'(mac_prod)
                    + (rsc_pkg::ACC_W+6)'(rsc_pkg::digit_value(in_beat.digit_char));
    assign mac_ovf  = |mac_sum[rsc_pkg::ACC_W+5:rsc_pkg::ACC_W];

    assign base_bad = (to_base_reg < rsc_pkg::BASE_MIN) || (to_base_reg > rsc_pkg::BASE_MAX);

    always_comb
    begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        ovf_next       = ovf_reg;
        err_next       = err_reg;
        value_next     = value_reg;
        to_base_next   = to_base_reg;
        count_next     = count_reg;
        tail_next      = tail_reg;
        mode_next      = mode_reg;
        out_valid_next = out_valid_reg;
        out_beat_next  = out_beat_reg;
        div_start      = 1'b0;
        store_wr       = '0;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (in_beat.last_digit)
                    begin
                        value_next   = mac_sum[rsc_pkg::ACC_W-1:0];
                        err_next     = ovf_reg || mac_ovf;
                        to_base_next = in_beat.to_base;
                        acc_next     = '0;
                        ovf_next     = 1'b0;
                        count_next   = '0;
                        state_next   = ST_CHECK;
                    end
                    else
                    begin
                        acc_next = mac_sum[rsc_pkg::ACC_W-1:0];
                        ovf_next = ovf_reg || mac_ovf;
                    end
                end
            end
            ST_CHECK:
            begin
                tail_next = TAIL_TOP;
                if (err_reg || base_bad)
                begin
                    mode_next  = rsc_pkg::FMT_ERROR;
                    state_next = ST_EMIT;
                end
                else if (value_reg == '0)
                begin
                    mode_next  = (count_reg == '0) ? rsc_pkg::FMT_ZERO : rsc_pkg::FMT_DIGITS;
                    state_next = ST_EMIT;
                end
                else if (count_reg >= FW_CNT)
                begin
                    mode_next  = rsc_pkg::FMT_ERROR;
                    state_next = ST_EMIT;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    store_wr.en    = 1'b1;
                    store_wr.idx   = count_reg;
                    store_wr.digit = div_rem[rsc_pkg::DIGIT_W-1:0];
                    value_next     = div_quot;
                    count_next     = count_reg + rsc_pkg::CNT_W'(1);
                    state_next     = ST_CHECK;
                end
            end
            ST_EMIT:
            begin
                if (emit_load)
                begin
                    out_valid_next          = 1'b1;
                    out_beat_next.out_char  = field_char;
                    out_beat_next.last_char = (tail_reg == '0);
                    tail_next               = tail_reg - rsc_pkg::CNT_W'(1);
                    if (tail_reg == '0)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            acc_reg       <= '0;
            ovf_reg       <= 1'b0;
            err_reg       <= 1'b0;
            count_reg     <= '0;
            tail_reg      <= '0;
            mode_reg      <= rsc_pkg::FMT_ZERO;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            ovf_reg       <= ovf_next;
            err_reg       <= err_next;
            count_reg     <= count_next;
            tail_reg      <= tail_next;
            mode_reg      <= mode_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg    <= value_next;
        to_base_reg  <= to_base_next;
        out_beat_reg <= out_beat_next;
    end

    rsc_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (value_reg),
        .divisor   (to_base_reg),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    assign fmt_ctl.mode  = mode_reg;
    assign fmt_ctl.count = count_reg;
    assign fmt_ctl.tail  = tail_reg;

    rsc_field_fmt #(
        .FIELD_WIDTH (FIELD_WIDTH)
    ) u_field_fmt (
        .clk        (clk),
        .wr         (store_wr),
        .rd_idx     (tail_next),
        .ctl        (fmt_ctl),
        .field_char (field_char)
    );

    assign out_valid = out_valid_reg;
    assign out_beat  = out_beat_reg;

    a_div_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (count_reg < FW_CNT))
        else $error("digit index beyond field");

    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside a division");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && in_beat.last_digit) |=> (state_reg == ST_CHECK && acc_reg == '0
                                             && !ovf_reg && count_reg == '0))
        else $error("number state not cleared on last character");

    a_digits_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && mode_reg == rsc_pkg::FMT_DIGITS) |-> (count_reg != '0))
        else $error("digit field with no digits");

endmodule

// ===== tb/sv/tb.sv =====
// tb: self-checking bench for radix_string_converter_core, directed table then random numbers
// depends on: rsc_pkg, radix_string_converter_core and its submodules
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FW            = 7;
    localparam int RANDOM_CHARS  = 246;
    localparam int QUIET_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 300;

    typedef logic [FW*8-1:0] field_text_t;

    typedef struct {
        rsc_pkg::in_beat_t beat;
        field_text_t       text;
    } dir_row_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    rsc_pkg::in_beat_t   in_beat;
    logic                out_valid;
    logic                out_ready;
    rsc_pkg::out_beat_t  out_beat;

    logic [31:0]         running_value;
    bit                  overflow_sticky;
    rsc_pkg::out_beat_t  pending_chars[$];
    dir_row_t            dir_rows[$];

    int errors;
    int chars_sent;
    int beats_checked;
    int fields_done;
    int fields_error;
    int fields_zero;
    int burst_left;
    int quiet_cycles;

    radix_string_converter_core #(.FIELD_WIDTH(FW)) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_beat   (in_beat),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_beat  (out_beat)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // horner accumulate, and on the last char the right-justified field in the target radix
    function automatic field_text_t horner_convert(input rsc_pkg::in_beat_t b);
        logic [7:0]   val;
        logic [63:0]  nxt;
        logic [31:0]  v;
        logic [3:0]   digs [FW];
        int           n;
        int           pad;
        bit           bad;
        field_text_t  t;
        logic [7:0]   ch;
        val = (b.digit_char >= rsc_pkg::CHAR_UPPER_A) ? b.digit_char - rsc_pkg::ALPHA_OFFSET
                                                      : b.digit_char - rsc_pkg::CHAR_ZERO;
        nxt = 64'(running_value) * 64'(b.from_base) + 64'(val);
        if (nxt[63:32] != 32'd0)
            overflow_sticky = 1'b1;
        running_value = nxt[31:0];
        if (!b.last_digit)
            return '0;
        v   = running_value;
        n   = 0;
        bad = (b.to_base < rsc_pkg::BASE_MIN) || (b.to_base > rsc_pkg::BASE_MAX);
        while (!bad && v != 32'd0)
        begin
            if (n >= FW)
                bad = 1'b1;
            else
            begin
                digs[n] = 4'(v % 32'(b.to_base));
                v = v / 32'(b.to_base);
                n++;
            end
        end
        if (overflow_sticky || bad)
        begin
            t = "  ERROR";
            fields_error++;
        end
        else if (n == 0)
        begin
            t = "      0";
            fields_zero++;
        end
        else
        begin
            pad = FW - n;
            for (int k = 0; k < FW; k++)
            begin
                ch = rsc_pkg::CHAR_SPACE;
                if (k >= pad)
                    ch = (digs[n-1-(k-pad)] > 4'd9) ?
                         8'(digs[n-1-(k-pad)]) - 8'd10 + rsc_pkg::CHAR_UPPER_A :
                         8'(digs[n-1-(k-pad)]) + rsc_pkg::CHAR_ZERO;
                t[8*(FW-1-k) +: 8] = ch;
            end
        end
        running_value   = '0;
        overflow_sticky = 1'b0;
        fields_done++;
        return t;
    endfunction

    function automatic void add_row(input logic [7:0] c, input int fb, input int tb_base,
                                    input bit last, input field_text_t text);
        dir_row_t r;
        r.beat.digit_char = c;
        r.beat.from_base  = 5'(fb);
        r.beat.to_base    = 5'(tb_base);
        r.beat.last_digit = last;
        r.text            = text;
        dir_rows.push_back(r);
    endfunction

    // text of all zeros means the field comes from the predictor
    task automatic send_char(input rsc_pkg::in_beat_t b, input field_text_t text);
        int                  gap;
        field_text_t         field;
        rsc_pkg::out_beat_t  ob;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
        end
        burst_left--;
        in_valid <= 1'b1;
        in_beat  <= b;
        do @(posedge clk); while (!in_ready);
        chars_sent++;
        field = horner_convert(b);
        if (b.last_digit)
        begin
            if (text != '0)
                field = text;
            for (int k = 0; k < FW; k++)
            begin
                ob.out_char  = field[8*(FW-1-k) +: 8];
                ob.last_char = (k == FW - 1);
                pending_chars.push_back(ob);
            end
        end
    endtask

    task automatic drain_pause();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_chars.size() != 0) @(posedge clk);
    endtask

    task automatic send_number();
        int                 len;
        int                 fb;
        int                 tbase;
        int                 d;
        int                 sel;
        bit                 noisy;
        bit                 zeros;
        rsc_pkg::in_beat_t  b;
        noisy = ($urandom_range(0, 9) == 0);
        zeros = ($urandom_range(0, 15) == 0);
        fb    = $urandom_range(2, 16);
        tbase = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) : $urandom_range(2, 16);
        sel   = $urandom_range(0, 9);
        len   = (sel < 6) ? $urandom_range(1, 3) :
                (sel < 9) ? $urandom_range(4, 6) : $urandom_range(7, 10);
        for (int i = 0; i < len; i++)
        begin
            d = zeros ? 0 : $urandom_range(0, fb - 1);
            b.digit_char = (d > 9) ? rsc_pkg::CHAR_UPPER_A + 8'(d - 10)
                                   : rsc_pkg::CHAR_ZERO + 8'(d);
            b.from_base  = 5'(fb);
            b.to_base    = (i == len - 1) ? 5'(tbase) : 5'($urandom_range(0, 31));
            b.last_digit = (i == len - 1);
            if (noisy || $urandom_range(0, 29) == 0)
            begin
                b.digit_char = 8'($urandom_range(0, 255));
                b.from_base  = 5'($urandom_range(0, 31));
            end
            send_char(b, '0);
        end
    endtask

    initial
    begin
        int random_start;
        int numbers;
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        in_beat         = '0;
        running_value   = '0;
        overflow_sticky = 1'b0;
        burst_left      = 0;

        add_row("0", 10, 10, 1'b1, "      0");
        add_row("F", 16, 2, 1'b1, "   1111");
        add_row("F", 16, 2, 1'b0, '0);
        add_row("F", 16, 2, 1'b1, "  ERROR");
        add_row("7", 16, 2, 1'b0, '0);
        add_row("F", 16, 2, 1'b1, "1111111");
        add_row("1", 16, 16, 1'b0, '0);
        add_row("0", 16, 16, 1'b0, '0);
        add_row("0", 16, 16, 1'b1, "    100");
        // accumulator overflow on the sixth char
        repeat (5) add_row(8'hFF, 31, 16, 1'b0, '0);
        add_row(8'hFF, 31, 16, 1'b1, "  ERROR");
        add_row("5", 10, 1, 1'b1, "  ERROR");
        add_row("5", 10, 17, 1'b1, "  ERROR");
        add_row("0", 10, 0, 1'b1, "  ERROR");
        add_row(8'h00, 10, 10, 1'b1, "    208");
        add_row("3", 0, 9, 1'b0, '0);
        add_row("7", 0, 8, 1'b1, '0);
        add_row("A", 11, 3, 1'b1, '0);
        add_row("1", 1, 5, 1'b0, '0);
        add_row("1", 1, 5, 1'b1, '0);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_char(dir_rows[i].beat, dir_rows[i].text);
        drain_pause();

        random_start = chars_sent;
        numbers      = 0;
        while (chars_sent - random_start < RANDOM_CHARS)
        begin
            send_number();
            numbers++;
            if (numbers == 20)
                drain_pause();
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_chars.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("%0d chars in, %0d fields converted (%0d error, %0d zero)",
                 chars_sent, fields_done, fields_error, fields_zero);
        $display("%0d out beats checked, %0d errors", beats_checked, errors);
        if (errors == 0 && pending_chars.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        int         mode;
        logic [7:0] ready_pattern;
        out_ready = 1'b0;
        forever
        begin
            mode          = $urandom_range(0, 2);
            ready_pattern = 8'($urandom_range(1, 255));
            for (int i = 0; i < 64; i++)
            begin
                @(posedge clk);
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= ($urandom_range(0, 9) < 7);
                    default: out_ready <= ready_pattern[i % 8];
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        rsc_pkg::out_beat_t want;
        if (rst_n && out_valid && out_ready)
        begin
            beats_checked++;
            if (pending_chars.size() == 0)
            begin
                $error("out beat 0x%02h with no char pending", out_beat.out_char);
                errors++;
            end
            else
            begin
                want = pending_chars.pop_front();
                if (out_beat.out_char !== want.out_char)
                begin
                    $error("out_char: expected 0x%02h, got 0x%02h",
                           want.out_char, out_beat.out_char);
                    errors++;
                end
                if (out_beat.last_char !== want.last_char)
                begin
                    $error("last_char: expected %0b, got %0b",
                           want.last_char, out_beat.last_char);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

endmodule

// ===== radix_string_converter_core.f =====
design/rsc_pkg.sv
design/rsc_divider.sv
design/rsc_field_fmt.sv
design/radix_string_converter_core.sv
tb/sv/tb.sv
